// File: hw/rtl/spz_pkg.sv
// Shared types, codes and small arithmetic helpers for the sliding puzzle
// expansion pipeline. No dependencies.
package spz_pkg;

  localparam int CELLS = 16;
  localparam logic [6:0] DIST_MAX = 7'd127;

  typedef logic [3:0] spz_cell_t;
  typedef spz_cell_t [CELLS-1:0] spz_board_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } spz_dir_t;

  typedef enum logic {
    REG_BOARD_ROWS = 1'b0,
    REG_BOARD_COLS = 1'b1
  } spz_reg_t;

  // State after the move, handed from the move stages to the distance stages.
  typedef struct packed {
    spz_board_t cells;
    logic [3:0] blank;
    logic       legal;
    logic       goal;
    logic [4:0] n;
    logic [2:0] cols;
  } spz_mid_t;

  // Fields that ride along with the distance pipeline unchanged.
  typedef struct packed {
    spz_board_t cells;
    logic [3:0] blank;
    logic       legal;
    logic       goal;
  } spz_pass_t;

  // Quotient of a small value (at most 16) by a column count of 1 to 7.
  // Divisors 3, 5, 6 and 7 use a reciprocal multiply that is exact over that range.
  function automatic logic [4:0] spz_div(input logic [4:0] x, input logic [2:0] cols);
    logic [9:0] prod;
    logic [4:0] q;
    prod = '0;
    q = x;
    case (cols)
      3'd2: q = {1'b0, x[4:1]};
      3'd3: begin
        prod = 10'(x) * 10'd11;
        q = prod[9:5];
      end
      3'd4: q = {2'b00, x[4:2]};
      3'd5: begin
        prod = 10'(x) * 10'd13;
        q = {1'b0, prod[9:6]};
      end
      3'd6: begin
        prod = 10'(x) * 10'd11;
        q = {1'b0, prod[9:6]};
      end
      3'd7: begin
        prod = 10'(x) * 10'd37;
        q = {3'b000, prod[9:8]};
      end
      default: q = x;
    endcase
    return q;
  endfunction

  function automatic logic [2:0] spz_mod(input logic [4:0] x, input logic [2:0] cols);
    logic [4:0] q;
    logic [7:0] qc;
    q = spz_div(x, cols);
    qc = 8'(q) * 8'(cols);
    return 3'(x - qc[4:0]);
  endfunction

endpackage

// File: hw/rtl/spz_item_if.sv
// Input channel of the expansion pipeline: valid/ready plus one packed state
// and a move direction. No dependencies.
interface spz_item_if;
  logic        valid;
  logic        ready;
  logic [3:0]  blank_position;
  logic [31:0] cells_low;
  logic [31:0] cells_high;
  logic [1:0]  move_dir;

  modport source (output valid, blank_position, cells_low, cells_high, move_dir,
                  input ready);
  modport sink (input valid, blank_position, cells_low, cells_high, move_dir,
                output ready);
endinterface

// File: hw/rtl/spz_result_if.sv
// Output channel of the expansion pipeline: valid/ready plus the successor
// state, legality, distance and goal flag. No dependencies.
interface spz_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  next_blank;
  logic [31:0] next_cells_low;
  logic [31:0] next_cells_high;
  logic        move_legal;
  logic [6:0]  next_distance;
  logic        input_at_goal;

  modport source (output valid, next_blank, next_cells_low, next_cells_high, move_legal,
                  next_distance, input_at_goal, input ready);
  modport sink (input valid, next_blank, next_cells_low, next_cells_high, move_legal,
                next_distance, input_at_goal, output ready);
endinterface

// File: hw/rtl/sliding_puzzle_expand_eval.sv
// Top level of the sliding puzzle node expansion pipeline: board size
// registers, move stages and distance stages. Depends on spz_pkg, the two
// channel interfaces, spz_move and spz_dist.

// The block takes one puzzle state and a move direction per cycle while ready is
// high and returns the successor state, a legality flag, the Manhattan distance
// of the successor and whether the input was the goal. The five register stages
// are move decode, tile swap, per-cell distance, partial sums and final sum, and
// each passes one item per cycle unless the stage ahead of it is full and stalled.
// Ready drops only when the result register is held by the sink and every stage
// behind it is full. Board rows and columns are set by writes to register 0
// and 1; the user must write them only while the block is idle, as the block
// itself does not enforce this.
module sliding_puzzle_expand_eval #(
  parameter int MAX_CELLS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         write_en,
  input  logic         write_index,
  input  logic [2:0]   write_data,
  spz_item_if.sink     item,
  spz_result_if.source result
);
  import spz_pkg::*;

  logic [2:0] board_rows;
  logic [2:0] board_cols;
  spz_mid_t   mid;
  logic       mid_valid;
  logic       mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_rows <= 3'd4;
      board_cols <= 3'd4;
    end else if (write_en) begin
      case (spz_reg_t'(write_index))
        REG_BOARD_ROWS: board_rows <= write_data;
        REG_BOARD_COLS: board_cols <= write_data;
        default: ;
      endcase
    end
  end

  spz_move #(
    .MAX_CELLS(MAX_CELLS)
  ) u_move (
    .clk       (clk),
    .rst       (rst),
    .board_rows(board_rows),
    .board_cols(board_cols),
    .item      (item),
    .mid       (mid),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready)
  );

  spz_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .mid      (mid),
    .mid_valid(mid_valid),
    .mid_ready(mid_ready),
    .result   (result)
  );

endmodule

// File: hw/rtl/spz_move.sv
// Stages one and two: board size, goal test, move legality, then the tile swap.
// Depends on spz_pkg and spz_item_if.
module spz_move #(
  parameter int MAX_CELLS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       board_rows,
  input  logic [2:0]       board_cols,
  spz_item_if.sink         item,
  output spz_pkg::spz_mid_t mid,
  output logic             mid_valid,
  input  logic             mid_ready
);
  import spz_pkg::*;

  // Stage one combinational signals.
  logic [2:0]  rows_e, cols_e;
  logic [5:0]  prod;
  logic [4:0]  n;
  spz_board_t  cells_in;
  logic        goal;
  logic [4:0]  b5;
  logic [2:0]  bcol;
  logic        cand;
  logic [4:0]  tgt;
  logic        legal;

  // Stage one registers.
  logic        v1;
  spz_board_t  c1;
  logic [3:0]  b1, t1;
  logic        l1, g1;
  logic [4:0]  n1;
  logic [2:0]  cols1;

  logic        en1, en2;
  spz_board_t  cells_next;

  assign en2 = !mid_valid || mid_ready;
  assign en1 = !v1 || en2;
  assign item.ready = en1;

  always_comb begin
    rows_e = (board_rows == 3'd0) ? 3'd1 : board_rows;
    cols_e = (board_cols == 3'd0) ? 3'd1 : board_cols;
    prod = 6'(rows_e) * 6'(cols_e);
    n = (prod > 6'(MAX_CELLS)) ? 5'(MAX_CELLS) : prod[4:0];
    cells_in = {item.cells_high, item.cells_low};

    goal = (item.blank_position == 4'd0);
    for (int p = 0; p < CELLS; p++) begin
      if (p >= 1 && 5'(p) < n) begin
        if (cells_in[p] != 4'(p - 1)) goal = 1'b0;
      end else begin
        if (cells_in[p] != 4'd0) goal = 1'b0;
      end
    end

    b5 = {1'b0, item.blank_position};
    bcol = spz_mod(b5, cols_e);
    cand = 1'b0;
    tgt = b5;
    case (spz_dir_t'(item.move_dir))
      DIR_UP: begin
        cand = (b5 >= 5'(cols_e));
        tgt = b5 - 5'(cols_e);
      end
      DIR_LEFT: begin
        cand = (bcol != 3'd0);
        tgt = b5 - 5'd1;
      end
      DIR_DOWN: begin
        cand = ((b5 + 5'(cols_e)) < n);
        tgt = b5 + 5'(cols_e);
      end
      DIR_RIGHT: begin
        cand = (bcol < (cols_e - 3'd1));
        tgt = b5 + 5'd1;
      end
      default: cand = 1'b0;
    endcase
    legal = (b5 < n) && cand && (tgt < n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item.valid;
    end
    if (en1 && item.valid) begin
      c1 <= cells_in;
      b1 <= item.blank_position;
      t1 <= tgt[3:0];
      l1 <= legal;
      g1 <= goal;
      n1 <= n;
      cols1 <= cols_e;
    end
  end

  // Stage two: the tile at the target slides into the old blank cell.
  always_comb begin
    cells_next = c1;
    if (l1) begin
      cells_next[b1] = c1[t1];
      cells_next[t1] = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en2) begin
      mid_valid <= v1;
    end
    if (en2 && v1) begin
      mid.cells <= cells_next;
      mid.blank <= l1 ? t1 : b1;
      mid.legal <= l1;
      mid.goal <= g1;
      mid.n <= n1;
      mid.cols <= cols1;
    end
  end

  a_legal_on_board: assert property (@(posedge clk) disable iff (rst)
    v1 && l1 |-> ({1'b0, t1} < n1) && ({1'b0, b1} < n1) && (t1 != b1))
    else $error("legal move with blank or target off the board");

  a_blank_cleared: assert property (@(posedge clk) disable iff (rst)
    mid_valid && mid.legal |-> mid.cells[mid.blank] == 4'd0)
    else $error("new blank cell not cleared after a legal move");

  a_illegal_unchanged: assert property (@(posedge clk) disable iff (rst)
    v1 && en2 && !l1 |=> (mid.cells == $past(c1)) && (mid.blank == $past(b1)))
    else $error("illegal move altered the state");

endmodule

// File: hw/rtl/spz_dist.sv
// Stages three to five: per-cell Manhattan distances, partial sums, final sum
// with saturation and the output register. Depends on spz_pkg and spz_result_if.
module spz_dist (
  input  logic              clk,
  input  logic              rst,
  input  spz_pkg::spz_mid_t mid,
  input  logic              mid_valid,
  output logic              mid_ready,
  spz_result_if.source      result
);
  import spz_pkg::*;

  function automatic logic [4:0] absdiff(input logic [4:0] a, input logic [4:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic        en3, en4, en5;
  logic        v3, v4, v5;
  logic [4:0]  d_next [CELLS];
  logic [4:0]  d3 [CELLS];
  spz_pass_t   pass3, pass4, pass5;
  logic [6:0]  grp_next [4];
  logic [6:0]  grp4 [4];
  logic [8:0]  total;
  logic [6:0]  dist5;

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign mid_ready = en3;

  // Stage three: each cell measures its own tile's distance from home.
  always_comb begin
    logic [4:0] aim;
    logic [4:0] pos;
    for (int p = 0; p < CELLS; p++) begin
      pos = 5'(p);
      aim = 5'(mid.cells[p]) + 5'd1;
      if (pos < mid.n && 4'(p) != mid.blank) begin
        d_next[p] = absdiff(spz_div(aim, mid.cols), spz_div(pos, mid.cols))
                  + absdiff(5'(spz_mod(aim, mid.cols)), 5'(spz_mod(pos, mid.cols)));
      end else begin
        d_next[p] = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= mid_valid;
    end
    if (en3 && mid_valid) begin
      d3 <= d_next;
      pass3 <= '{cells: mid.cells, blank: mid.blank, legal: mid.legal, goal: mid.goal};
    end
  end

  // Stage four: four groups of four.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_next[g] = 7'(d3[4*g]) + 7'(d3[4*g+1]) + 7'(d3[4*g+2]) + 7'(d3[4*g+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4 && v3) begin
      grp4 <= grp_next;
      pass4 <= pass3;
    end
  end

  // Stage five: final sum, clipped to the field's range.
  assign total = 9'(grp4[0]) + 9'(grp4[1]) + 9'(grp4[2]) + 9'(grp4[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
    if (en5 && v4) begin
      dist5 <= (total > 9'(DIST_MAX)) ? DIST_MAX : total[6:0];
      pass5 <= pass4;
    end
  end

  assign result.valid = v5;
  assign result.next_blank = pass5.blank;
  assign result.next_cells_low = pass5.cells[7:0];
  assign result.next_cells_high = pass5.cells[15:8];
  assign result.move_legal = pass5.legal;
  assign result.next_distance = dist5;
  assign result.input_at_goal = pass5.goal;

  a_blank_not_counted: assert property (@(posedge clk) disable iff (rst)
    v3 |-> d3[pass3.blank] == 5'd0)
    else $error("blank cell contributed to the distance");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    v5 && !result.ready |=> v5)
    else $error("waiting result dropped");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v3 && en4 |=> v4 && (pass4 == $past(pass3)))
    else $error("item lost between distance stages");

endmodule
